### hdl/ssd_pkg.sv
// Shared types, codes and constants for the seven-segment serial display driver.
package ssd_pkg;

    typedef logic [1:0]  t_op;
    typedef logic [15:0] t_value;
    typedef logic [7:0]  t_seg;

    localparam t_op OP_TICK   = 2'd0;
    localparam t_op OP_LOAD   = 2'd1;
    localparam t_op OP_RESEND = 2'd2;

    localparam int FRAME_BYTES = 9;
    localparam int BYTE_IDX_W  = $clog2(FRAME_BYTES);

    localparam logic [BYTE_IDX_W-1:0] IDX_LUX_THIRD   = BYTE_IDX_W'(0);
    localparam logic [BYTE_IDX_W-1:0] IDX_LUX_FIRST   = BYTE_IDX_W'(1);
    localparam logic [BYTE_IDX_W-1:0] IDX_LUX_SECOND  = BYTE_IDX_W'(2);
    localparam logic [BYTE_IDX_W-1:0] IDX_LED_LOW     = BYTE_IDX_W'(3);
    localparam logic [BYTE_IDX_W-1:0] IDX_LED_MIXED   = BYTE_IDX_W'(4);
    localparam logic [BYTE_IDX_W-1:0] IDX_VOLT_THIRD  = BYTE_IDX_W'(5);
    localparam logic [BYTE_IDX_W-1:0] IDX_VOLT_FIRST  = BYTE_IDX_W'(6);
    localparam logic [BYTE_IDX_W-1:0] IDX_VOLT_SECOND = BYTE_IDX_W'(7);
    localparam logic [BYTE_IDX_W-1:0] IDX_LED_HIGH    = BYTE_IDX_W'(8);
    localparam logic [BYTE_IDX_W-1:0] IDX_LAST        = BYTE_IDX_W'(FRAME_BYTES - 1);

    localparam t_seg SEG_BLANK     = 8'hFF;
    localparam t_seg SEG_LED_MIXED = 8'h71;
    localparam t_seg SEG_DP_MASK   = 8'h7F;

    localparam t_value INT_LIMIT = 16'd999;

    // Reciprocal constants: floor(v*M >> S) equals v/N for every 16-bit v.
    localparam logic [15:0] RCP_10    = 16'd52429;   // >> 19
    localparam logic [17:0] RCP_100   = 18'd167773;  // >> 24
    localparam logic [16:0] RCP_1000  = 17'd67109;   // >> 26
    localparam logic [18:0] RCP_10000 = 19'd429497;  // >> 32

    function automatic t_seg seg_code(input logic [3:0] digit);
        t_seg code;
        unique case (digit)
            4'd0:    code = 8'h88;
            4'd1:    code = 8'hEE;
            4'd2:    code = 8'h94;
            4'd3:    code = 8'hC4;
            4'd4:    code = 8'hE2;
            4'd5:    code = 8'hC1;
            4'd6:    code = 8'h81;
            4'd7:    code = 8'hEC;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'hC0;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

### hdl/ssd_in_if.sv
// Command channel: operation code and the two values to display.
interface ssd_in_if;
    import ssd_pkg::*;

    logic   valid;
    logic   ready;
    t_op    operation;
    t_value voltage_value;
    t_value lux_value;

    modport source (output valid, output operation, output voltage_value,
                    output lux_value, input ready);
    modport sink   (input valid, input operation, input voltage_value,
                    input lux_value, output ready);
endinterface

### hdl/ssd_out_if.sv
// Result channel: pin levels and status after each command beat.
interface ssd_out_if;
    import ssd_pkg::*;

    logic valid;
    logic ready;
    logic data_pin;
    logic clock_pin;
    logic strobe_pin;
    logic frame_done;
    logic busy_res;
    logic rejected;

    modport source (output valid, output data_pin, output clock_pin, output strobe_pin,
                    output frame_done, output busy_res, output rejected, input ready);
    modport sink   (input valid, input data_pin, input clock_pin, input strobe_pin,
                    input frame_done, input busy_res, input rejected, output ready);
endinterface

### hdl/seven_segment_serial_display_driver.sv
// Top level: formats two values into a 9-byte frame and bit-bangs it to a shift chain.
//
// Usage: each beat on i_in carries an operation: tick (0, also 3), load (1) or resend (2).
// Every accepted beat yields exactly one beat on o_out with the data, clock and strobe
// line levels, frame_done, busy_res and rejected. A load formats both values into the
// frame and starts sending; a resend sends the stored frame again; both are rejected
// while a frame is in progress. Each tick while sending moves the serial sequence one
// step: clock up with data, clock down, and after 72 bits strobe up, strobe down.
// A command beat is registered in the input register, processed from there and its
// result is registered in the output register. One beat is taken per cycle while the
// receiver takes results; the step state machine and output register set that rate.
// Digit formatting runs in a two-stage side pipeline of constant-reciprocal multiplies;
// its bytes land before the frame reaches them.
// Reset (i_rst_n low, synchronous) clears both channel registers and the step state,
// drives all lines low and fills the frame with blanks and the fixed mixed-LED byte.
// When the receiver stalls, the result waits in the output register and one further
// command waits in the input register; i_in.ready drops only when both are full.
module seven_segment_serial_display_driver (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssd_in_if.sink    i_in,
    ssd_out_if.source o_out
);
    import ssd_pkg::*;

    typedef enum logic [1:0] {
        PH_CLK_RISE,
        PH_CLK_FALL,
        PH_STB_RISE,
        PH_STB_FALL
    } t_phase;

    // input register
    logic   r_in_vld;
    t_op    r_in_op;
    t_value r_in_volt;
    t_value r_in_lux;

    // step state
    t_phase                r_phase,    n_phase;
    logic [BYTE_IDX_W-1:0] r_byte_pos, n_byte_pos;
    logic [2:0]            r_bit_pos,  n_bit_pos;
    logic                  r_sending,  n_sending;
    logic                  r_data,     n_data;
    logic                  r_clk,      n_clk;
    logic                  r_stb,      n_stb;
    logic                  n_done;
    logic                  n_rej;
    logic                  n_fmt_start;

    // output register
    logic r_out_vld;
    logic r_out_done;
    logic r_out_rej;

    t_seg r_frame [FRAME_BYTES];
    t_seg w_cur_byte;

    logic w_advance;

    assign w_advance  = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_op   <= i_in.operation;
            r_in_volt <= i_in.voltage_value;
            r_in_lux  <= i_in.lux_value;
        end
    end

    assign w_cur_byte = (32'(r_byte_pos) < FRAME_BYTES) ? r_frame[r_byte_pos] : SEG_BLANK;

    always_comb begin
        n_phase     = r_phase;
        n_byte_pos  = r_byte_pos;
        n_bit_pos   = r_bit_pos;
        n_sending   = r_sending;
        n_data      = r_data;
        n_clk       = r_clk;
        n_stb       = r_stb;
        n_done      = 1'b0;
        n_rej       = 1'b0;
        n_fmt_start = 1'b0;
        unique case (r_in_op)
            OP_LOAD, OP_RESEND: begin
                if (r_sending) begin
                    n_rej = 1'b1;
                end else begin
                    n_sending   = 1'b1;
                    n_phase     = PH_CLK_RISE;
                    n_byte_pos  = IDX_LAST;
                    n_bit_pos   = 3'd0;
                    n_fmt_start = (r_in_op == OP_LOAD);
                end
            end
            default: begin
                if (r_sending) begin
                    unique case (r_phase)
                        PH_CLK_RISE: begin
                            n_data  = w_cur_byte[r_bit_pos];
                            n_clk   = 1'b1;
                            n_phase = PH_CLK_FALL;
                        end
                        PH_CLK_FALL: begin
                            n_clk     = 1'b0;
                            n_bit_pos = r_bit_pos + 3'd1;
                            n_phase   = PH_CLK_RISE;
                            if (r_bit_pos == 3'd7) begin
                                if (r_byte_pos == '0 || 32'(r_byte_pos) >= FRAME_BYTES) begin
                                    n_byte_pos = IDX_LAST;
                                    n_phase    = PH_STB_RISE;
                                end else begin
                                    n_byte_pos = r_byte_pos - BYTE_IDX_W'(1);
                                end
                            end
                        end
                        PH_STB_RISE: begin
                            n_stb   = 1'b1;
                            n_phase = PH_STB_FALL;
                        end
                        PH_STB_FALL: begin
                            n_stb     = 1'b0;
                            n_phase   = PH_CLK_RISE;
                            n_sending = 1'b0;
                            n_done    = 1'b1;
                        end
                        default: begin
                            n_phase = PH_CLK_RISE;
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_CLK_RISE;
            r_byte_pos <= IDX_LAST;
            r_bit_pos  <= 3'd0;
            r_sending  <= 1'b0;
            r_data     <= 1'b0;
            r_clk      <= 1'b0;
            r_stb      <= 1'b0;
            r_out_vld  <= 1'b0;
            r_out_done <= 1'b0;
            r_out_rej  <= 1'b0;
        end else begin
            if (w_advance) begin
                r_phase    <= n_phase;
                r_byte_pos <= n_byte_pos;
                r_bit_pos  <= n_bit_pos;
                r_sending  <= n_sending;
                r_data     <= n_data;
                r_clk      <= n_clk;
                r_stb      <= n_stb;
                r_out_vld  <= 1'b1;
                r_out_done <= n_done;
                r_out_rej  <= n_rej;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.data_pin   = r_data;
    assign o_out.clock_pin  = r_clk;
    assign o_out.strobe_pin = r_stb;
    assign o_out.frame_done = r_out_done;
    assign o_out.busy_res   = r_sending;
    assign o_out.rejected   = r_out_rej;

    // Format stage A: quotients by 10, 100, 1000, 10000 through reciprocal multiplies.
    logic        r_fa_vld;
    t_value      r_fa_v   [2];
    logic [12:0] r_fa_q10 [2];
    logic [9:0]  r_fa_q100 [2];
    logic [6:0]  r_fa_q1k [2];
    logic [2:0]  r_fa_q10k [2];

    logic [31:0] w_p10  [2];
    logic [33:0] w_p100 [2];
    logic [32:0] w_p1k  [2];
    logic [34:0] w_p10k [2];
    t_value      w_src  [2];

    assign w_src[0] = r_in_volt;
    assign w_src[1] = r_in_lux;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            w_p10[i]  = 32'(w_src[i]) * 32'(RCP_10);
            w_p100[i] = 34'(w_src[i]) * 34'(RCP_100);
            w_p1k[i]  = 33'(w_src[i]) * 33'(RCP_1000);
            w_p10k[i] = 35'(w_src[i]) * 35'(RCP_10000);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fa_vld <= 1'b0;
        end else begin
            r_fa_vld <= w_advance && n_fmt_start;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 2; i++) begin
            r_fa_v[i]    <= w_src[i];
            r_fa_q10[i]  <= w_p10[i][31:19];
            r_fa_q100[i] <= w_p100[i][33:24];
            r_fa_q1k[i]  <= w_p1k[i][32:26];
            r_fa_q10k[i] <= w_p10k[i][34:32];
        end
    end

    // Format stage B: digits by subtraction, segment codes, frame write.
    t_seg        w_first  [2];
    t_seg        w_second [2];
    t_seg        w_third  [2];
    logic [15:0] w_ones   [2];
    logic [12:0] w_tens   [2];
    logic [9:0]  w_hund   [2];
    logic [6:0]  w_thou   [2];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            w_ones[i] = r_fa_v[i] - (16'(r_fa_q10[i]) * 16'd10);
            w_tens[i] = r_fa_q10[i] - (13'(r_fa_q100[i]) * 13'd10);
            w_hund[i] = r_fa_q100[i] - (10'(r_fa_q1k[i]) * 10'd10);
            w_thou[i] = r_fa_q1k[i] - (7'(r_fa_q10k[i]) * 7'd10);
            if (r_fa_v[i] <= INT_LIMIT) begin
                w_third[i]  = seg_code(w_ones[i][3:0]);
                w_second[i] = (r_fa_q10[i] != '0) ? seg_code(w_tens[i][3:0]) : SEG_BLANK;
                w_first[i]  = (r_fa_q100[i] != '0) ? seg_code(w_hund[i][3:0]) : SEG_BLANK;
            end else begin
                w_third[i]  = seg_code(w_hund[i][3:0]);
                w_second[i] = seg_code(w_thou[i][3:0]) & SEG_DP_MASK;
                w_first[i]  = (r_fa_q10k[i] != '0) ? seg_code({1'b0, r_fa_q10k[i]})
                                                    : SEG_BLANK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < FRAME_BYTES; j++) begin
                r_frame[j] <= (j == int'(IDX_LED_MIXED)) ? SEG_LED_MIXED : SEG_BLANK;
            end
        end else if (r_fa_vld) begin
            r_frame[IDX_VOLT_FIRST]  <= w_first[0];
            r_frame[IDX_VOLT_SECOND] <= w_second[0];
            r_frame[IDX_VOLT_THIRD]  <= w_third[0];
            r_frame[IDX_LUX_FIRST]   <= w_first[1];
            r_frame[IDX_LUX_SECOND]  <= w_second[1];
            r_frame[IDX_LUX_THIRD]   <= w_third[1];
        end
    end

    // checks
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_done |-> !r_sending && !r_stb)
        else $error("frame_done with frame still active");

    a_fmt_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fa_vld |-> r_sending && r_byte_pos == IDX_LAST)
        else $error("digit write outside the head of a frame");

    a_clk_stb_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_clk && r_stb))
        else $error("clock and strobe high together");

    a_rej_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && n_rej |=> r_sending == $past(r_sending) && r_phase == $past(r_phase))
        else $error("rejected command changed the step state");

endmodule
